@@ rtl/core/rem_pkg.sv @@
`default_nettype none

package rem_pkg;

	localparam int PIX_W       = 8;
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int SUMSQ_W     = 17;
	localparam int ROOT_W      = SUMSQ_W + 1;
	localparam int SQRT_STEPS  = (SUMSQ_W + 1) / 2;
	localparam int STEPS_PER_CYC = 3;
	localparam int SQRT_CYCLES = SQRT_STEPS / STEPS_PER_CYC;
	localparam int MIN_DIM     = 3;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIFF,
		ST_ROOT
	} rem_state_t;

endpackage

`default_nettype wire

@@ rtl/core/rem_pixel_if.sv @@
`default_nettype none

interface rem_pixel_if;
	logic              valid;
	logic              ready;
	rem_pkg::pix_t     pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rem_result_if.sv @@
`default_nettype none

interface rem_result_if;
	logic              valid;
	logic              ready;
	rem_pkg::pix_t     edge_magnitude;
	rem_pkg::pix_t     abs_first_diff;
	rem_pkg::pix_t     abs_second_diff;
	logic              frame_end;

	modport source (output valid, output edge_magnitude, output abs_first_diff,
		output abs_second_diff, output frame_end, input ready);
	modport sink   (input valid, input edge_magnitude, input abs_first_diff,
		input abs_second_diff, input frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rem_cfg_if.sv @@
`default_nettype none

interface rem_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [rem_pkg::CFG_IDX_W-1:0]       index;
	logic [rem_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/roberts_edge_magnitude_top.sv @@
// Channel   Role  Payload                                                  Request
// pixels    sink  pixel[7:0]                                               one raster pixel
// results   src   edge_magnitude, abs_first_diff, abs_second_diff, frame_end  one result
// cfg       sink  index[7:0], data[15:0]                                   register write
//
// One pixel at a time: line-store read, differences and squares, the iterative
// root (3 bit pairs per cycle), then load of the result register.
// Line store is a 1-port-write, 2-port-read RAM, not cleared; no clearing pass.
// Reset clears counters, the upper-left register and restores 640 x 480.
// A full result register stalls the root stage; pixels are taken only when idle.
`default_nettype none

module roberts_edge_magnitude_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	rem_pixel_if.sink      pixels,
	rem_result_if.source   results,
	rem_cfg_if.sink        cfg
);
	import rem_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

	rem_state_t state_q, state_d;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [AW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;
	pix_t                ul_q;

	logic [AW:0]         w_eff;
	logic [AW-1:0]       last_col, addr_j1;
	logic [HEIGHT_W-1:0] last_row;

	pix_t row_mem [MAX_WIDTH];
	pix_t above_s1, ur_s1, pix_s1;
	logic inner_s1, fe_s1;

	pix_t                a1, a2, a1_s2, a2_s2;
	logic [15:0]         sq1, sq2;
	logic [SUMSQ_W-1:0]  sumsq;
	logic                fe_s2;

	logic in_acc, cfg_acc, cfg_hit, out_free, root_start, root_done, load_out;
	pix_t root;

	logic res_valid_q, fe_q;
	pix_t mag_q, ad1_q, ad2_q;

	always_comb begin
		if (32'(width_q) < MIN_DIM) begin
			w_eff = (AW + 1)'(MIN_DIM);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = (AW + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (AW + 1)'(width_q);
		end
		last_col = AW'(w_eff - 1'b1);
		last_row = (height_q < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM - 1)
			: height_q - 1'b1;
		addr_j1 = (col_q == LAST_ADDR) ? '0 : col_q + 1'b1;
	end

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid & cfg.ready;
	assign cfg_hit   = cfg_acc & ((cfg.index == REG_IMAGE_WIDTH)
		|| (cfg.index == REG_IMAGE_HEIGHT));
	assign out_free  = !res_valid_q || results.ready;

	always_comb begin
		state_d       = state_q;
		pixels.ready  = 1'b0;
		root_start    = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pixels.ready = 1'b1;
				if (pixels.valid) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				root_start = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_done && out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_acc = pixels.valid & pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
			ul_q     <= '0;
		end else begin
			if (in_acc) begin
				if (col_q >= last_col) begin
					col_q <= '0;
					row_q <= (row_q >= last_row) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (state_q == ST_DIFF) begin
				ul_q <= above_s1;
			end
			if (cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
				if (cfg.index == REG_IMAGE_WIDTH) begin
					width_q <= cfg.data[WIDTH_W-1:0];
				end else begin
					height_q <= cfg.data[HEIGHT_W-1:0];
				end
			end
		end
	end

	// line store: read-first on the written entry
	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_s1     <= row_mem[col_q];
			ur_s1        <= row_mem[addr_j1];
			row_mem[col_q] <= pixels.pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1   <= pixels.pixel;
			inner_s1 <= (row_q != '0) && (row_q < last_row)
				&& (col_q != '0) && (col_q < last_col);
			fe_s1    <= (row_q == last_row) && (col_q == last_col);
		end
	end

	always_comb begin
		a1 = '0;
		a2 = '0;
		if (inner_s1) begin
			a1 = (pix_s1 >= ul_q) ? pix_s1 - ul_q : ul_q - pix_s1;
			a2 = (pix_s1 >= ur_s1) ? pix_s1 - ur_s1 : ur_s1 - pix_s1;
		end
		sq1   = 16'(a1) * 16'(a1);
		sq2   = 16'(a2) * 16'(a2);
		sumsq = SUMSQ_W'(sq1) + SUMSQ_W'(sq2);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			a1_s2 <= a1;
			a2_s2 <= a2;
			fe_s2 <= fe_s1;
		end
	end

	rem_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sumsq),
		.done     (root_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mag_q <= root;
			ad1_q <= a1_s2;
			ad2_q <= a2_s2;
			fe_q  <= fe_s2;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.edge_magnitude  = mag_q;
	assign results.abs_first_diff  = ad1_q;
	assign results.abs_second_diff = ad2_q;
	assign results.frame_end       = fe_q;

endmodule

`default_nettype wire

@@ rtl/core/rem_isqrt.sv @@
`default_nettype none

module rem_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rem_pkg::SUMSQ_W-1:0]  radicand,
	output logic                         done,
	output rem_pkg::pix_t                root
);
	import rem_pkg::*;

	logic [ROOT_W-1:0] n_q, r_q, n_v, r_v, r_fin;
	logic [1:0]        step_q;
	logic              busy_q, done_q;

	// three bit-pair steps of the restoring root per cycle
	always_comb begin
		int k;
		logic [ROOT_W-1:0] b, trial;
		n_v = n_q;
		r_v = r_q;
		for (int s = 0; s < STEPS_PER_CYC; s++) begin
			k = STEPS_PER_CYC * int'(step_q) + s;
			b = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
			trial = r_v + b;
			if (n_v >= trial) begin
				n_v = n_v - trial;
				r_v = (r_v >> 1) + b;
			end else begin
				r_v = r_v >> 1;
			end
		end
	end

	// round to nearest (no ties), then saturate
	always_comb begin
		r_fin = (n_q > r_q) ? r_q + 1'b1 : r_q;
		root  = (r_fin > ROOT_W'(255)) ? '1 : r_fin[PIX_W-1:0];
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == 2'(SQRT_CYCLES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= ROOT_W'(radicand);
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= n_v;
			r_q <= r_v;
		end
	end

endmodule

`default_nettype wire
